FILE: hw/rtl/plst_pkg.sv
package plst_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [2:0] {
    KIND_ADD_HEAD = 3'd0,
    KIND_ADD_TAIL = 3'd1,
    KIND_INSERT   = 3'd2,
    KIND_ERASE    = 3'd3,
    KIND_READ     = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_ADJUSTED   = 3'd1,
    STAT_FULL       = 3'd2,
    STAT_EMPTY      = 3'd3,
    STAT_READ_RANGE = 3'd4
  } status_t;

  // What every cell of the chain does on a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ERASE  = 2'd2,
    CELL_READ   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_ctl_t;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_RESULT = 1'b1
  } fsm_state_t;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 3;

endpackage

FILE: hw/rtl/plst_cell.sv
module plst_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  plst_pkg::cell_ctl_t ctl,
  input  logic [IDX_W-1:0]   target,
  input  logic signed [31:0] from_prev,
  input  logic signed [31:0] from_next,
  output logic signed [31:0] entry,
  output logic signed [31:0] pick
);
  import plst_pkg::*;

  logic hit;
  logic after;

  assign hit   = (IDX_W'(INDEX) == target);
  assign after = (IDX_W'(INDEX) > target);

  // Shift toward the tail on insert, toward the head on erase
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        if (after) begin
          entry <= from_prev;
        end else if (hit) begin
          entry <= ctl.value;
        end
      end
      CELL_ERASE: begin
        if (after || hit) begin
          entry <= from_next;
        end
      end
      default: begin
      end
    endcase
  end

  // Offer the held entry to the read bus only when addressed
  assign pick = (ctl.op == CELL_READ && hit) ? entry : '0;

endmodule

FILE: hw/rtl/positional_list_engine_top.sv
// Positional list engine: a bounded ordered list of up to CAPACITY signed
// 32-bit entries, held in a chain of identical cells, one entry per cell with
// the head in cell 0. The operation code arrives on s_tuser; push front, push
// back, insert at a 1-based position, erase at a position and read at a
// position are supported, and position 0 acts on the head. Inserts and erases
// shift the cells at and after the target toward their neighbors in the same
// clock edge that accepts the transaction. Each input transaction yields
// exactly one result transaction carrying the status, the count after the
// operation (reported modulo 32) and, for a successful read, the entry. An
// item passes through two states: the accept state updates the chain and
// captures the addressed entry from the merged read bus of all cells, the
// result state moves the finished result into the output register once it
// is free. The next item is accepted as soon as that result sits in the
// output register, so a stalled consumer holds at most one finished result
// plus one waiting to be loaded. Inserts past the end append with status
// "adjusted", erases past the end drop the tail with status "adjusted", full
// and empty lists reject with their own status and leave the list as is.
// Entries beyond the count are never visible; no clearing pass follows reset.
module positional_list_engine_top #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: value [31:0], position [39:32]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // s_tuser: kind [2:0]
  input  logic [2:0]  s_tuser,
  // m_tdata: status [2:0], count [7:3], read_value [39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata
);
  import plst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > 8) ? CW : 8;

  fsm_state_t state;
  fsm_state_t state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] count_m1;
  status_t       res_status;
  status_t       status_next;

  logic accept;
  logic load;

  kind_t              kind;
  logic signed [31:0] value;
  logic [7:0]         position;

  logic [PW-1:0] pos_x;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] cnt_x;
  logic          full;
  logic          empty;
  logic          beyond;

  cell_op_t    op;
  logic [IW-1:0] target;
  cell_ctl_t   ctl;

  logic signed [31:0] entries [CAPACITY];
  logic signed [31:0] picks   [CAPACITY];
  logic signed [31:0] read_word;
  logic signed [31:0] res_read;

  // Unpack the input transaction
  assign kind     = kind_t'(s_tuser);
  assign value    = s_tdata[31:0];
  assign position = s_tdata[39:32];

  // Position 0 means the head
  assign pos_x    = (position == 8'd0) ? PW'(1) : PW'(position);
  assign pos_m1   = pos_x - PW'(1);
  assign cnt_x    = PW'(count);
  assign count_m1 = count - CW'(1);
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign beyond   = (pos_x > cnt_x);

  // Decode the operation into a shift command for the chain
  always_comb begin
    op          = CELL_HOLD;
    target      = '0;
    status_next = STAT_OK;
    count_next  = count;
    case (kind)
      KIND_ADD_HEAD: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          op         = CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      KIND_ADD_TAIL: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          op         = CELL_INSERT;
          target     = count[IW-1:0];
          count_next = count + CW'(1);
        end
      end
      KIND_INSERT: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          op         = CELL_INSERT;
          count_next = count + CW'(1);
          if (beyond) begin
            status_next = STAT_ADJUSTED;
            target      = count[IW-1:0];
          end else begin
            target = pos_m1[IW-1:0];
          end
        end
      end
      KIND_ERASE: begin
        if (empty) begin
          status_next = STAT_EMPTY;
        end else begin
          op         = CELL_ERASE;
          count_next = count_m1;
          if (beyond) begin
            status_next = STAT_ADJUSTED;
            target      = count_m1[IW-1:0];
          end else begin
            target = pos_m1[IW-1:0];
          end
        end
      end
      KIND_READ: begin
        if (beyond) begin
          status_next = STAT_READ_RANGE;
        end else begin
          op     = CELL_READ;
          target = pos_m1[IW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Cells act only on the edge that accepts a transaction
  assign ctl.op    = accept ? op : CELL_HOLD;
  assign ctl.value = value;

  // Chain of cells; each takes its neighbors' entries for shifting
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_entry;
    logic signed [31:0] next_entry;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_entry = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_body
      assign next_entry = entries[i+1];
    end

    plst_cell #(
      .INDEX (i),
      .IDX_W (IW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .target    (target),
      .from_prev (prev_entry),
      .from_next (next_entry),
      .entry     (entries[i]),
      .pick      (picks[i])
    );
  end

  // Merge the read bus: at most one cell offers a nonzero word
  always_comb begin
    read_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_word = read_word | picks[i];
    end
  end

  // Sequencer: accept, then hand the result to the output register
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load       = 1'b0;
    case (state)
      FSM_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = FSM_RESULT;
        end
      end
      FSM_RESULT: begin
        if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          state_next = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FSM_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
      end
      m_tvalid <= load || (m_tvalid && !m_tready);
    end
  end

  // Payload registers: hold status and read word until the result is formed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      res_read   <= read_word;
    end
    if (load) begin
      m_tdata <= {res_read, COUNT_W'(count), res_status};
    end
  end

endmodule

FILE: bench/plst_result_checker.sv
module plst_result_checker #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          fail_count,
  output int          outstanding
);
  import plst_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [4:0]         count;
    logic signed [31:0] read_value;
  } list_result_t;

  // Shadow copy of the list, head at index 0
  logic signed [31:0] list_vals[$];
  // Results owed by the block, oldest first
  list_result_t       owed_results[$];
  list_result_t       want;
  list_result_t       got;
  int                 results_seen;

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  function automatic list_result_t apply_list_op(input logic [2:0] kind,
                                                 input logic signed [31:0] value,
                                                 input logic [7:0] position);
    int unsigned  at;
    int unsigned  held;
    list_result_t res;
    at             = (position == 8'd0) ? 1 : position;
    held           = list_vals.size();
    res.status     = STAT_OK;
    res.read_value = '0;
    case (kind)
      KIND_ADD_HEAD: begin
        if (held >= CAPACITY) res.status = STAT_FULL;
        else list_vals = {value, list_vals};
      end
      KIND_ADD_TAIL: begin
        if (held >= CAPACITY) res.status = STAT_FULL;
        else list_vals = {list_vals, value};
      end
      KIND_INSERT: begin
        if (held >= CAPACITY) begin
          res.status = STAT_FULL;
        end else if (at > held) begin
          res.status = STAT_ADJUSTED;
          list_vals = {list_vals, value};
        end else begin
          list_vals.insert(at - 1, value);
        end
      end
      KIND_ERASE: begin
        if (held == 0) begin
          res.status = STAT_EMPTY;
        end else if (at > held) begin
          res.status = STAT_ADJUSTED;
          void'(list_vals.pop_back());
        end else begin
          list_vals.delete(at - 1);
        end
      end
      KIND_READ: begin
        if (at > held) res.status = STAT_READ_RANGE;
        else res.read_value = list_vals[at - 1];
      end
      default: ;
    endcase
    res.count = 5'(list_vals.size());
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint want_v,
                                 input longint got_v);
    $display("mismatch on result %0d, %s: expected %0d, got %0d",
             results_seen, what, want_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_vals.delete();
      owed_results.delete();
      outstanding <= 0;
    end else begin
      if (s_tvalid && s_tready)
        owed_results = {owed_results, apply_list_op(s_tuser, $signed(s_tdata[31:0]),
                                                    s_tdata[39:32])};
      if (m_tvalid && m_tready) begin
        got.status     = status_t'(m_tdata[2:0]);
        got.count      = m_tdata[7:3];
        got.read_value = $signed(m_tdata[39:8]);
        if (owed_results.size() == 0) begin
          report_mismatch("result with no operation pending, status", -1, got.status);
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
          if (got.count !== want.count)
            report_mismatch("count", want.count, got.count);
          if (got.read_value !== want.read_value)
            report_mismatch("read_value", want.read_value, got.read_value);
        end
        results_seen++;
      end
      outstanding <= owed_results.size();
    end
  end

endmodule

FILE: bench/positional_list_engine_top_tb.sv
module positional_list_engine_top_tb;
  import plst_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 550;
  // Final stretch of the random part runs with no idling on either side
  localparam int QUIET_ITEMS  = 100;
  localparam int LONG_HOLD    = 64;
  localparam int CYCLE_LIMIT  = 100000;

  // Codes the block does not define; it must answer them and change nothing
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // s_tdata: value [31:0], position [39:32]
  logic [39:0] s_tdata;
  // s_tuser: kind [2:0]
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // m_tdata: status [2:0], count [7:3], read_value [39:8]
  logic [39:0] m_tdata;

  int          fail_count;
  int          outstanding;
  int          cycle_count;
  bit          tx_gaps;
  bit          rx_gaps;
  bit          hold_req;

  positional_list_engine_top #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  plst_result_checker #(
    .CAPACITY(CAPACITY)
  ) checker_inst (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: bail out if the run stops making progress
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one operation, optionally after a short idle burst, and hold it
  // until the transaction completes. Valid is never dropped between two
  // back-to-back items.
  task automatic send_op(input logic [2:0] kind, input logic signed [31:0] value,
                         input logic [7:0] position);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {position, value};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Pick one random operation. The filling mood leans toward pushes and
  // inserts so the list hits full; the other mood leans toward erases so it
  // drains to empty. Report whether the operation is one the block acts on.
  task automatic send_random_op(input bit filling, output bit counted);
    int unsigned        roll;
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         position;
    roll = $urandom_range(0, 99);
    if (roll < 3) kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    else if (roll < 15) kind = KIND_READ;
    else if (roll < (filling ? 80 : 35))
      kind = 3'($urandom_range(KIND_ADD_HEAD, KIND_INSERT));
    else kind = KIND_ERASE;
    // Mostly ordinary values, now and then the signed extremes
    case ($urandom_range(0, 19))
      0:       value = 32'sh7FFF_FFFF;
      1:       value = 32'sh8000_0000;
      2:       value = 32'sh0;
      3:       value = -32'sh1;
      default: value = $urandom;
    endcase
    // Keep most positions near the live range; the rest span the full field
    if ($urandom_range(0, 99) < 85) position = 8'($urandom_range(0, CAPACITY + 1));
    else position = 8'($urandom);
    send_op(kind, value, position);
    counted = (kind <= KIND_READ);
  endtask

  // Receiver: runs of ready, short stalls, and one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned done;
    bit          filling;
    bit          counted;
    tx_gaps  = 1'b1;
    rx_gaps  = 1'b1;
    hold_req = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= KIND_ADD_HEAD;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list cases first
    send_op(KIND_READ, 32'sd0, 8'd0);
    send_op(KIND_ERASE, 32'sd0, 8'd3);
    // Insert past the end on an empty list appends
    send_op(KIND_INSERT, 32'sd5, 8'd9);
    send_op(KIND_ADD_TAIL, 32'sh7FFF_FFFF, 8'd0);
    send_op(KIND_ADD_HEAD, 32'sh8000_0000, 8'd0);
    // Position zero acts on the head
    send_op(KIND_INSERT, -32'sd1, 8'd0);
    send_op(KIND_INSERT, 32'sd0, 8'd2);
    send_op(KIND_READ, 32'sd0, 8'd0);
    send_op(KIND_READ, 32'sd0, 8'd255);
    send_op(KIND_SPARE_LO, 32'sh7FFF_FFFF, 8'd1);
    // Erase past the end drops the tail
    send_op(KIND_ERASE, 32'sd0, 8'd255);
    send_op(KIND_ERASE, 32'sd0, 8'd0);
    send_op(KIND_INSERT, 32'sd123, 8'd3);
    // Fill to capacity, then every add must be rejected
    repeat (CAPACITY - 4)
      send_op(3'($urandom_range(KIND_ADD_HEAD, KIND_INSERT)), $urandom,
              8'($urandom_range(0, 5)));
    send_op(KIND_ADD_HEAD, 32'sd1, 8'd0);
    send_op(KIND_ADD_TAIL, 32'sd2, 8'd0);
    send_op(KIND_INSERT, 32'sd3, 8'd4);
    send_op(KIND_READ, 32'sd0, 8'(CAPACITY));
    send_op(KIND_SPARE_HI, 32'sd0, 8'd255);

    // Random part: alternate moods so the list sweeps between empty and full
    done    = 0;
    filling = 1'b1;
    while (done < RANDOM_ITEMS) begin
      if ($urandom_range(0, 29) == 0) filling = !filling;
      // Stall the receiver for a long stretch while items keep coming
      if (done == 80) hold_req = 1'b1;
      if (done == RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      send_random_op(filling, counted);
      if (counted) done++;
    end
    s_tvalid <= 1'b0;

    // Drain: let the checker see the last acceptance, then wait it out
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/plst_pkg.sv
hw/rtl/plst_cell.sv
hw/rtl/positional_list_engine_top.sv
bench/plst_result_checker.sv
bench/positional_list_engine_top_tb.sv
